FILE: rtl/core/sssb_pkg.sv
// Shared types and constants for the seven-segment scan driver with blinking.
// Holds request and mode codes, field widths and the segment decode function.
// No dependencies.
`default_nettype none

package sssb_pkg;

	// field widths fixed by the interface
	localparam int CHAR_W  = 5;
	localparam int PHASE_W = 7;
	localparam int SEG_W   = 8;
	localparam int DRIVE_W = 4;
	localparam int SCAN_W  = 2;
	localparam int INDEX_W = 2;
	localparam int MODE_W  = 2;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [SEG_W-1:0]   seg_t;
	typedef logic [MODE_W-1:0]  mode_t;

	// request types
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_CMD  = 1'b1;

	// digit modes
	localparam mode_t MODE_OFF   = 2'd0;
	localparam mode_t MODE_ON    = 2'd1;
	localparam mode_t MODE_BLINK = 2'd2;
	localparam mode_t MODE_CHAR  = 2'd3;	// store the character only

	// reset values
	localparam char_t  CHAR_RESET  = 5'd8;
	localparam phase_t PHASE_RESET = 7'd25;

	// Active-low segment pattern: bits 0-6 = a-g, bit 7 = point.
	// Codes past the table show blank.
	function automatic seg_t seg_decode(input char_t code);
		seg_t on_pat;
		unique case (code)
			5'd0:  on_pat = 8'h3f;
			5'd1:  on_pat = 8'h06;
			5'd2:  on_pat = 8'h5b;
			5'd3:  on_pat = 8'h4f;
			5'd4:  on_pat = 8'h66;
			5'd5:  on_pat = 8'h6d;
			5'd6:  on_pat = 8'h7d;
			5'd7:  on_pat = 8'h07;
			5'd8:  on_pat = 8'h7f;
			5'd9:  on_pat = 8'h6f;
			5'd10: on_pat = 8'h77;
			5'd11: on_pat = 8'h7c;
			5'd12: on_pat = 8'h39;
			5'd13: on_pat = 8'h5e;
			5'd14: on_pat = 8'h79;
			5'd15: on_pat = 8'h71;
			5'd16: on_pat = 8'h74;
			5'd17: on_pat = 8'h63;
			5'd18: on_pat = 8'hbf;
			5'd19: on_pat = 8'h86;
			5'd20: on_pat = 8'hdb;
			5'd21: on_pat = 8'hcf;
			5'd22: on_pat = 8'he6;
			5'd23: on_pat = 8'hed;
			5'd24: on_pat = 8'hfd;
			5'd25: on_pat = 8'h87;
			5'd26: on_pat = 8'hff;
			5'd27: on_pat = 8'hef;
			default: on_pat = 8'h00;
		endcase
		return ~on_pat;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/seven_segment_scan_with_blink_core.sv
// A tick request's result goes to the output register, or to the skid register while the output stalls (out_valid).
// Throughput: one request per cycle while in_stall is low; command requests give no result.
// in_stall rises only when both the output register and the skid register are full.
// Reset (arst_n low, asynchronous): chars all 8, all digits dark and not blinking,
// scan slot 0, blink counter idle, blink phase 25 frames, output empty.
// Depends on: sssb_pkg.
`default_nettype none

module seven_segment_scan_with_blink_core #(
	parameter int NUM_DIGITS = 4
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration
	input  wire                            cfg_wr_en,
	input  wire [sssb_pkg::PHASE_W-1:0]    cfg_wr_data,
	// request channel
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            req_type,
	input  wire [sssb_pkg::INDEX_W-1:0]    digit_index,
	input  wire [sssb_pkg::MODE_W-1:0]     digit_mode,
	input  wire [sssb_pkg::CHAR_W-1:0]     char_code,
	// result channel
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [sssb_pkg::SEG_W-1:0]     segment_pattern,
	output logic [sssb_pkg::DRIVE_W-1:0]   digit_drive,
	output logic [sssb_pkg::SCAN_W-1:0]    scan_slot
);

	localparam int SLOT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_DIGITS - 1);

	// state
	sssb_pkg::phase_t         phase_q;
	sssb_pkg::char_t          chars_q [NUM_DIGITS];
	logic [NUM_DIGITS-1:0]    lit_q;
	logic [NUM_DIGITS-1:0]    blink_q;
	logic [NUM_DIGITS-1:0]    prev_q;
	logic [SLOT_W-1:0]        slot_q;
	sssb_pkg::phase_t         count_q;
	logic                     idle_q;

	sssb_pkg::char_t          chars_n [NUM_DIGITS];
	logic [NUM_DIGITS-1:0]    lit_n;
	logic [NUM_DIGITS-1:0]    blink_n;
	logic [NUM_DIGITS-1:0]    prev_n;
	logic [SLOT_W-1:0]        slot_n;
	sssb_pkg::phase_t         count_n;
	logic                     idle_n;

	// frame logic intermediates
	logic                     started;
	logic                     stopped;
	logic                     ref_on;
	logic [NUM_DIGITS-1:0]    lit_a;
	sssb_pkg::phase_t         count_inc;

	// result of the current request
	logic                     accept;
	logic                     res_valid;
	sssb_pkg::seg_t           res_seg;
	logic [sssb_pkg::DRIVE_W-1:0] res_drive;
	logic [sssb_pkg::SCAN_W-1:0]  res_slot;

	// output and skid registers
	logic                     out_valid_q;
	sssb_pkg::seg_t           out_seg_q;
	logic [sssb_pkg::DRIVE_W-1:0] out_drive_q;
	logic [sssb_pkg::SCAN_W-1:0]  out_slot_q;
	logic                     skid_valid_q;
	sssb_pkg::seg_t           skid_seg_q;
	logic [sssb_pkg::DRIVE_W-1:0] skid_drive_q;
	logic [sssb_pkg::SCAN_W-1:0]  skid_slot_q;

	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign res_valid = accept && (req_type == sssb_pkg::REQ_TICK);

	// next state for one request
	always_comb begin
		chars_n   = chars_q;
		lit_n     = lit_q;
		blink_n   = blink_q;
		prev_n    = prev_q;
		slot_n    = slot_q;
		count_n   = count_q;
		idle_n    = idle_q;
		started   = |(~prev_q & blink_q);
		stopped   = |(prev_q & ~blink_q);
		lit_a     = lit_q;
		ref_on    = 1'b0;
		count_inc = count_q + 7'd1;

		if (req_type == sssb_pkg::REQ_CMD) begin
			// command: store char and apply mode to the addressed digit
			for (int i = 0; i < NUM_DIGITS; i++) begin
				if (32'(digit_index) == i) begin
					chars_n[i] = char_code;
					unique case (digit_mode)
						sssb_pkg::MODE_BLINK: blink_n[i] = 1'b1;
						sssb_pkg::MODE_ON: begin
							lit_n[i]   = 1'b1;
							blink_n[i] = 1'b0;
						end
						sssb_pkg::MODE_OFF: begin
							lit_n[i]   = 1'b0;
							blink_n[i] = 1'b0;
						end
						default: ;
					endcase
				end
			end
		end else begin
			// tick: advance slot, frame logic on wrap to slot zero
			slot_n = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
			if (slot_n == '0) begin
				if (started) lit_a = lit_a | blink_q;
				if (stopped) lit_a = lit_a & blink_q;
				prev_n = blink_q;
				lit_n  = lit_a;
				if (!(|blink_q)) begin
					idle_n  = 1'b1;
					count_n = '0;
				end else if (idle_q) begin
					idle_n  = 1'b0;
					count_n = '0;
				end else if (count_inc == phase_q) begin
					// toggle all blinking digits against the common phase
					ref_on  = |(lit_a & blink_q);
					lit_n   = ref_on ? (lit_a & ~blink_q) : (lit_a | blink_q);
					count_n = '0;
				end else begin
					count_n = count_inc;
				end
			end
		end
	end

	// result fields for the new slot
	always_comb begin
		res_seg   = sssb_pkg::seg_decode(chars_n[slot_n]);
		res_slot  = sssb_pkg::SCAN_W'(slot_n);
		res_drive = '0;
		for (int j = 0; j < sssb_pkg::DRIVE_W; j++) begin
			res_drive[j] = lit_n[slot_n] && (32'(slot_n) == j);
		end
	end

	// configuration and display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sssb_pkg::PHASE_RESET;
			for (int i = 0; i < NUM_DIGITS; i++) chars_q[i] <= sssb_pkg::CHAR_RESET;
			lit_q   <= '0;
			blink_q <= '0;
			prev_q  <= '0;
			slot_q  <= '0;
			count_q <= '0;
			idle_q  <= 1'b1;
		end else begin
			if (cfg_wr_en) phase_q <= cfg_wr_data;
			if (accept) begin
				chars_q <= chars_n;
				lit_q   <= lit_n;
				blink_q <= blink_n;
				prev_q  <= prev_n;
				slot_q  <= slot_n;
				count_q <= count_n;
				idle_q  <= idle_n;
			end
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q  <= res_valid;
				end
			end else if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload of output and skid registers
	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_seg_q   <= skid_seg_q;
				out_drive_q <= skid_drive_q;
				out_slot_q  <= skid_slot_q;
			end else if (res_valid) begin
				out_seg_q   <= res_seg;
				out_drive_q <= res_drive;
				out_slot_q  <= res_slot;
			end
		end else if (res_valid) begin
			skid_seg_q   <= res_seg;
			skid_drive_q <= res_drive;
			skid_slot_q  <= res_slot;
		end
	end

	assign out_valid       = out_valid_q;
	assign segment_pattern = out_seg_q;
	assign digit_drive     = out_drive_q;
	assign scan_slot       = out_slot_q;

endmodule

`default_nettype wire

FILE: rtl/core/sssb_checker.sv
// Port-level checks for the seven-segment scan driver, bound to its top level.
// Depends on: seven_segment_scan_with_blink_core ports.
`default_nettype none

module sssb_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_stall,
	input wire       out_valid,
	input wire       out_stall,
	input wire [7:0] segment_pattern,
	input wire [3:0] digit_drive,
	input wire [1:0] scan_slot
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(segment_pattern)
			&& $stable(digit_drive) && $stable(scan_slot))
		else $error("stalled result changed");

	// at most one digit switched on
	a_drive_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(digit_drive))
		else $error("digit drive not one-hot");

	// the lit digit is the slot being shown
	a_drive_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (digit_drive != 4'd0) |-> digit_drive == (4'd1 << scan_slot))
		else $error("digit drive does not match scan slot");

	// request side stalls only with a result waiting
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("request stalled with empty output");

endmodule

bind seven_segment_scan_with_blink_core sssb_checker u_sssb_checker (.*);

`default_nettype wire
